### rtl/core/linked_index_queue_top_macros.svh
// ----------------------------------------------------------------------------
// linked_index_queue_top_macros.svh
// Assertion macros used by the linked index queue checker.
// ----------------------------------------------------------------------------
`ifndef LINKED_INDEX_QUEUE_TOP_MACROS_SVH
`define LINKED_INDEX_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LNQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LNQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lnq_pkg.sv
// ----------------------------------------------------------------------------
// lnq_pkg
// Field widths, operation and status codes of the linked index queue.
// ----------------------------------------------------------------------------
package lnq_pkg;

    localparam int IDX_W = 10;
    localparam int CNT_W = 11;

    // Reset value of the entries_in_use register.
    localparam logic [CNT_W-1:0] ENTRIES_RESET = 11'd1024;

    typedef enum logic
    {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

### rtl/core/lnq_cfg_if.sv
// ----------------------------------------------------------------------------
// lnq_cfg_if
// Configuration write channel: entries_in_use write data.
// ----------------------------------------------------------------------------
interface lnq_cfg_if;

    logic                        valid;
    logic                        ready;
    logic [lnq_pkg::CNT_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### rtl/core/lnq_cmd_if.sv
// ----------------------------------------------------------------------------
// lnq_cmd_if
// Command channel: one enqueue or dequeue item.
// ----------------------------------------------------------------------------
interface lnq_cmd_if;

    logic                        valid;
    logic                        ready;
    lnq_pkg::mode_t              mode;
    logic [lnq_pkg::IDX_W-1:0]   entry_index;

    modport source (output valid, output mode, output entry_index, input ready);
    modport sink   (input valid, input mode, input entry_index, output ready);

endinterface

### rtl/core/lnq_rsp_if.sv
// ----------------------------------------------------------------------------
// lnq_rsp_if
// Response channel: status, dequeued index and queue count.
// ----------------------------------------------------------------------------
interface lnq_rsp_if;

    logic                        valid;
    logic                        ready;
    lnq_pkg::status_t            status;
    logic [lnq_pkg::IDX_W-1:0]   head_index;
    logic [lnq_pkg::CNT_W-1:0]   queued_count;

    modport source (output valid, output status, output head_index, output queued_count,
                    input ready);
    modport sink   (input valid, input status, input head_index, input queued_count,
                    output ready);

endinterface

### rtl/core/lnq_ram.sv
// ----------------------------------------------------------------------------
// lnq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lnq_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/linked_index_queue_top.sv
// ----------------------------------------------------------------------------
// linked_index_queue_top
// FIFO of entry indices kept as a linked list in a next-pointer RAM.
// ----------------------------------------------------------------------------
// A command is taken only while no earlier command is still at work. The
// accept cycle issues reads of the membership flag RAM and the link RAM; the
// S_EXEC state then checks the flag, writes the flag RAM and, for an enqueue
// behind a tail, the link RAM, and loads the response register. A finished
// response waits in its own output register, so the next command is accepted
// while it is held. A response that has not been taken when the next one is
// ready stalls that command in its write-back cycle. After reset a clearing
// pass zeroes the membership flags; cmd.ready stays low during it, while
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module linked_index_queue_top #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    lnq_cfg_if.sink     cfg,
    lnq_cmd_if.sink     cmd,
    lnq_rsp_if.source   rsp
);

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int IDX_W = lnq_pkg::IDX_W;
    localparam int CNT_W = lnq_pkg::CNT_W;

    typedef enum logic [2:0]
    {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    // Map a 10-bit index onto a RAM address of whatever width the depth needs.
    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [AW+IDX_W-1:0] wide;
        wide = {{AW{1'b0}}, idx};
        return wide[AW-1:0];
    endfunction

    // Control and queue state
    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    limit_reg;

    // Captured command
    lnq_pkg::mode_t      mode_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                range_err_reg;

    // Response register
    logic                out_valid_reg, out_valid_next;
    lnq_pkg::status_t    out_status_reg;
    logic [IDX_W-1:0]    out_head_reg;
    logic [CNT_W-1:0]    out_count_reg;

    // RAM ports
    logic                flag_we, flag_wdata, flag_rdata;
    logic [AW-1:0]       flag_waddr;
    logic                link_we;
    logic [AW-1:0]       link_waddr;
    logic [IDX_W-1:0]    link_wdata, link_rdata;

    logic                cmd_fire;
    logic                range_err;
    logic                exec_done;
    logic                enq_ok, deq_ok;
    lnq_pkg::status_t    status;
    logic [CNT_W-1:0]    count_dec;

    assign cfg.ready = 1'b1;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Reject indices at or above the configured limit or the table depth.
    assign range_err = ({1'b0, cmd.entry_index} >= limit_reg)
                    || (32'(cmd.entry_index) >= MAX_ENTRIES);

    // Write back only when the response register is free or being drained.
    assign exec_done = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign count_dec = count_reg - 1'b1;

    lnq_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ENTRIES)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (cmd_fire),
        .raddr (to_addr(cmd.entry_index)),
        .rdata (flag_rdata)
    );

    lnq_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (cmd_fire),
        .raddr (to_addr(head_reg)),
        .rdata (link_rdata)
    );

    // Decide the outcome from the count, the captured range check and the registered flag read.
    always_comb
    begin
        enq_ok = 1'b0;
        deq_ok = 1'b0;
        if (mode_reg == lnq_pkg::MODE_DEQ)
        begin
            if (count_reg == '0)
            begin
                status = lnq_pkg::ST_EMPTY;
            end
            else
            begin
                status = lnq_pkg::ST_OK;
                deq_ok = 1'b1;
            end
        end
        else if (range_err_reg)
        begin
            status = lnq_pkg::ST_RANGE;
        end
        else if (flag_rdata)
        begin
            status = lnq_pkg::ST_DUP;
        end
        else
        begin
            status = lnq_pkg::ST_OK;
            enq_ok = 1'b1;
        end
    end

    // Next state, pointers and RAM writes
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        flag_we       = 1'b0;
        flag_waddr    = to_addr(idx_reg);
        flag_wdata    = 1'b0;
        link_we       = 1'b0;
        link_waddr    = to_addr(tail_reg);
        link_wdata    = idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the flag RAM, one entry a cycle.
                flag_we       = 1'b1;
                flag_waddr    = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MAX_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = S_IDLE;
                    if (enq_ok)
                    begin
                        // Mark the index and link it after the tail, or make it the head of an empty list.
                        flag_we    = 1'b1;
                        flag_wdata = 1'b1;
                        link_we    = (count_reg != '0);
                        if (count_reg == '0)
                        begin
                            head_next = idx_reg;
                        end
                        tail_next  = idx_reg;
                        count_next = count_reg + 1'b1;
                    end
                    else if (deq_ok)
                    begin
                        // Drop the head's flag and follow its link while entries remain.
                        flag_we    = 1'b1;
                        flag_waddr = to_addr(head_reg);
                        count_next = count_dec;
                        if (count_dec != '0)
                        begin
                            head_next = link_rdata;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            limit_reg     <= lnq_pkg::ENTRIES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.data;
            end
        end
    end

    // Payload registers: captured command and response
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            mode_reg      <= cmd.mode;
            idx_reg       <= cmd.entry_index;
            range_err_reg <= range_err;
        end
        if (exec_done)
        begin
            out_status_reg <= status;
            out_head_reg   <= deq_ok ? head_reg : '0;
            out_count_reg  <= count_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.head_index   = out_head_reg;
    assign rsp.queued_count = out_count_reg;

endmodule

### rtl/core/lnq_checker.sv
// ----------------------------------------------------------------------------
// lnq_checker
// Port-level checks of the linked index queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "linked_index_queue_top_macros.svh"

module lnq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [1:0]                  status,
    input logic [lnq_pkg::IDX_W-1:0]   head_index,
    input logic [lnq_pkg::CNT_W-1:0]   queued_count
);

    // Hold a stalled response.
    `LNQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "response dropped")
    `LNQ_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
        $stable(status) && $stable(head_index) && $stable(queued_count), "response changed")

    // A command is busy for its write-back cycle after acceptance.
    `LNQ_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "command taken early")

    // Failed operations return a zero index; an empty queue reports zero count.
    `LNQ_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && status != lnq_pkg::ST_OK,
        head_index == '0, "nonzero index on error")
    `LNQ_ASSERT_IMP(a_empty_cnt, clk, rst_n, out_valid && status == lnq_pkg::ST_EMPTY,
        queued_count == '0, "empty status with nonzero count")

endmodule

bind linked_index_queue_top lnq_checker u_lnq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cmd.valid),
    .in_ready     (cmd.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .status       (rsp.status),
    .head_index   (rsp.head_index),
    .queued_count (rsp.queued_count)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linked index queue. A backlog of enqueue and
// dequeue commands feeds a valid/ready driver. A local copy of the list state
// computes the response of every accepted command, and a monitor compares each
// response, field by field, against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          IDX_W       = lnq_pkg::IDX_W;
    localparam int          CNT_W       = lnq_pkg::CNT_W;
    localparam int          MAX_ENTRIES = 1024;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed
    {
        lnq_pkg::mode_t     mode;
        logic [IDX_W-1:0]   entry_index;
        logic               drain;          // hold until every response is back
    } cmd_item_t;

    typedef struct packed
    {
        lnq_pkg::status_t   status;
        logic [IDX_W-1:0]   head_index;
        logic [CNT_W-1:0]   queued_count;
    } rsp_item_t;

    logic clk;
    logic rst_n;

    lnq_cfg_if cfg_bus ();
    lnq_cmd_if cmd_bus ();
    lnq_rsp_if rsp_bus ();

    linked_index_queue_top #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Commands waiting to be driven, and responses owed by the block in order.
    cmd_item_t   cmd_backlog[$];
    rsp_item_t   owed_rsps[$];

    // Shadow copy of the list: links, membership, ends, length and the limit.
    logic [IDX_W-1:0]   next_link [0:MAX_ENTRIES-1] = '{default: '0};
    logic               on_list   [0:MAX_ENTRIES-1] = '{default: 1'b0};
    logic [IDX_W-1:0]   list_head = '0;
    logic [IDX_W-1:0]   list_tail = '0;
    logic [CNT_W-1:0]   list_len  = '0;
    logic [CNT_W-1:0]   entries_limit;

    // Percentage of items followed by a gap, on both sides; zero for stretches
    // at full rate.
    int unsigned idle_pct;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    cmd_item_t   next_cmd;
    rsp_item_t   want_rsp;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Apply one command to the shadow list and return the response it owes.
    // Indices are 10 bits wide, so the table-size bound never rejects one; the
    // configured limit alone decides the range check, and it comes before the
    // membership check. Rejected and empty operations leave the state alone.
    function automatic rsp_item_t queue_op(lnq_pkg::mode_t mode, logic [IDX_W-1:0] idx);
        rsp_item_t r;
        r.status     = lnq_pkg::ST_OK;
        r.head_index = '0;
        if (mode == lnq_pkg::MODE_ENQ)
        begin
            if ({1'b0, idx} >= entries_limit)
                r.status = lnq_pkg::ST_RANGE;
            else if (on_list[idx])
                r.status = lnq_pkg::ST_DUP;
            else
            begin
                if (list_len == 0)
                    list_head = idx;
                else
                    next_link[list_tail] = idx;
                list_tail    = idx;
                on_list[idx] = 1'b1;
                list_len     = list_len + 1'b1;
            end
        end
        else if (list_len == 0)
            r.status = lnq_pkg::ST_EMPTY;
        else
        begin
            // Follow the link only while something remains; the ends are
            // left stale once the list runs empty.
            r.head_index       = list_head;
            on_list[list_head] = 1'b0;
            list_len           = list_len - 1'b1;
            if (list_len != 0)
                list_head = next_link[list_head];
        end
        r.queued_count = list_len;
        return r;
    endfunction

    function automatic void add_cmd(lnq_pkg::mode_t mode, logic [IDX_W-1:0] idx,
                                    logic drain);
        cmd_item_t c;
        c.mode        = mode;
        c.entry_index = idx;
        c.drain       = drain;
        cmd_backlog.push_back(c);
    endfunction

    // Random commands: enq_pct sets the enqueue share and idx_hi the top index,
    // so a small limit with idx_hi just past it yields range errors, duplicates
    // and empty dequeues, while the full range builds long lists.
    function automatic void random_burst(int unsigned count, int unsigned enq_pct,
                                         int unsigned idx_hi);
        for (int unsigned i = 0; i < count; i++)
        begin
            add_cmd(($urandom_range(0, 99) < enq_pct) ? lnq_pkg::MODE_ENQ
                                                      : lnq_pkg::MODE_DEQ,
                    IDX_W'($urandom_range(0, idx_hi)),
                    $urandom_range(0, 49) == 0);
        end
    endfunction

    // Wait until the block has no command in flight and owes no response.
    task automatic wait_quiet();
        while (cmd_backlog.size() != 0 || cmd_bus.valid || owed_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write entries_in_use; only called while the block is quiet, so the
    // shadow limit can follow at the accepting edge.
    task automatic write_limit(logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        entries_limit = value;
        cfg_bus.valid <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // Driver: present the head of the backlog whenever the slot is free, then
    // hold off for a random gap. A command marked drain waits until every
    // response owed so far has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid       <= 1'b0;
            cmd_bus.mode        <= lnq_pkg::MODE_ENQ;
            cmd_bus.entry_index <= '0;
            gap_left            <= 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                owed_rsps.push_back(queue_op(cmd_bus.mode, cmd_bus.entry_index));
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    cmd_bus.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain && owed_rsps.size() != 0))
                begin
                    next_cmd             = cmd_backlog.pop_front();
                    cmd_bus.valid       <= 1'b1;
                    cmd_bus.mode        <= next_cmd.mode;
                    cmd_bus.entry_index <= next_cmd.entry_index;
                    gap_left            <= ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: check every accepted response against the oldest one owed,
    // and stall the response channel at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (owed_rsps.size() == 0)
                begin
                    if (error_count < 10)
                        $display("response with none outstanding: status %0d head %0d count %0d",
                                 rsp_bus.status, rsp_bus.head_index, rsp_bus.queued_count);
                    error_count++;
                end
                else
                begin
                    want_rsp = owed_rsps.pop_front();
                    if (rsp_bus.status !== want_rsp.status ||
                        rsp_bus.head_index !== want_rsp.head_index ||
                        rsp_bus.queued_count !== want_rsp.queued_count)
                    begin
                        if (error_count < 10)
                            $display("mismatch: exp st %0d hd %0d cnt %0d, got st %0d hd %0d cnt %0d",
                                     want_rsp.status, want_rsp.head_index,
                                     want_rsp.queued_count, rsp_bus.status,
                                     rsp_bus.head_index, rsp_bus.queued_count);
                        error_count++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if ($urandom_range(0, 99) < idle_pct)
                    stall_left <= pick_gap();
            end
        end
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        // Hold the configuration channel at a known value from time zero.
        rst_n               = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.data        = '0;
        idle_pct            = 20;
        entries_limit       = lnq_pkg::ENTRIES_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset limit: empty dequeue, both index extremes,
        // duplicates, draining back to empty through the single-entry case,
        // and alternating bit patterns. The driver waits out the clearing
        // pass on its own since cmd.ready stays low.
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd0, 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd1023, 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd0, 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, 10'd1023, 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, 10'd0, 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'h2AA, 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'h155, 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b0);
        wait_quiet();

        // Zero limit rejects every enqueue with a range error.
        write_limit(11'd0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd0, 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd1023, 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b0);
        wait_quiet();

        write_limit(11'd4);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd3, 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd4, 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd2, 1'b0);
        wait_quiet();

        // Shrink below a queued index: it reports out of range ahead of
        // duplicate, yet stays queued and dequeues normally. One command
        // waits for the block to drain first.
        write_limit(11'd2);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd3, 1'b0);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd1, 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b1);
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b0);
        wait_quiet();

        // Limit above the table size: every index is in range.
        write_limit(11'h7FF);
        add_cmd(lnq_pkg::MODE_ENQ, 10'd1023, 1'b0);
        add_cmd(lnq_pkg::MODE_DEQ, IDX_W'($urandom_range(0, 1023)), 1'b0);
        wait_quiet();

        // Random phases. Small limits with indices just past them stress the
        // range, duplicate and empty paths; the full range builds long lists.
        idle_pct = 30;
        write_limit(11'd8);
        random_burst(60, 55, 11);
        wait_quiet();

        idle_pct = 0;
        write_limit(lnq_pkg::ENTRIES_RESET);
        random_burst(80, 70, 1023);
        wait_quiet();

        idle_pct = 30;
        write_limit(11'h7FF);
        random_burst(60, 40, 1023);
        wait_quiet();

        begin
            logic [CNT_W-1:0] lim;
            lim = CNT_W'($urandom_range(1, 64));
            idle_pct = 50;
            write_limit(lim);
            random_burst(60, 55, lim + 3);
        end
        wait_quiet();

        idle_pct = 15;
        write_limit(11'd1);
        random_burst(30, 50, 2);
        wait_quiet();

        idle_pct = 20;
        write_limit(CNT_W'($urandom_range(1, 1024)));
        random_burst(80, 60, 1023);
        wait_quiet();

        idle_pct = 0;
        write_limit(11'd16);
        random_burst(40, 50, 19);
        wait_quiet();

        // Let any trailing activity settle, then report.
        repeat (20) @(posedge clk);
        if (error_count == 0 && owed_rsps.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lnq_pkg.sv
rtl/core/lnq_cfg_if.sv
rtl/core/lnq_cmd_if.sv
rtl/core/lnq_rsp_if.sv
rtl/core/lnq_ram.sv
rtl/core/linked_index_queue_top.sv
rtl/core/lnq_checker.sv
tb/sv/testbench.sv
